### hw/rtl/prpn_pkg.sv
// Shared constants, types and command/status structs for the PageRank pull node update.
// No dependencies; every other file of the block imports this package.
package prpn_pkg;

  // Fraction bits of ranks, sums and tolerance (ranks and tolerance Q16.16, sums Q32.16 by default).
  localparam int FRAC_BITS = 16;
  // The damping factor is always Q1.16 (one is 65536).
  localparam int DAMP_FRAC = 16;

  localparam int RANK_W  = 32;
  localparam int DEG_W   = 24;
  localparam int SUM_W   = 48;
  localparam int DAMP_W  = 17;
  localparam int HALF_W  = SUM_W / 2;
  localparam int PROD_W  = DAMP_W + HALF_W;
  localparam int ACC_W   = PROD_W + HALF_W;
  localparam int CNT_W   = $clog2(RANK_W);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b1;

  localparam logic [DAMP_W-1:0] DAMP_ONE    = 17'd65536;
  localparam logic [DAMP_W-1:0] DAMP_RESET  = 17'd55706;
  localparam logic [RANK_W-1:0] TOL_RESET   = 32'd6554;
  localparam logic [SUM_W-1:0]  SUM_MAX     = {SUM_W{1'b1}};
  localparam logic [RANK_W-1:0] RANK_MAX    = {RANK_W{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted item
    logic div_start;  // start dividing rank by out-degree
    logic acc;        // add the quotient to the running sum
    logic mul_lo;     // damping times low half of the sum
    logic mul_hi;     // damping times high half of the sum
    logic fin;        // combine partial products and jump term, saturate
    logic emit;       // compare with old rank, load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_work;    // offered item carries an edge with nonzero out-degree
    logic in_last;    // offered item closes the node
    logic node_last;  // captured item closes the node
    logic div_done;   // quotient is ready
    logic out_free;   // result register can take a new result this cycle
  } status_t;

endpackage

### hw/rtl/prpn_in_if.sv
// Input channel of the node update: one in-edge item per handshake.
// Depends on prpn_pkg for field widths.
interface prpn_in_if import prpn_pkg::*;;
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] neighbor_rank;
  logic [DEG_W-1:0]  neighbor_outdeg;
  logic              has_edge;
  logic              last_edge;
  logic [RANK_W-1:0] old_rank;

  modport source (output valid, neighbor_rank, neighbor_outdeg, has_edge, last_edge,
                  old_rank, input ready);
  modport sink (input valid, neighbor_rank, neighbor_outdeg, has_edge, last_edge,
                old_rank, output ready);
endinterface

### hw/rtl/prpn_out_if.sv
// Output channel of the node update: one result item per completed node.
// Depends on prpn_pkg for field widths.
interface prpn_out_if import prpn_pkg::*;;
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] new_rank;
  logic              changed;

  modport source (output valid, new_rank, changed, input ready);
  modport sink (input valid, new_rank, changed, output ready);
endinterface

### hw/rtl/prpn_div.sv
// Restoring divider, one quotient bit per cycle, for rank / out-degree.
// Depends on prpn_pkg.
module prpn_div import prpn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RANK_W-1:0] dividend,
  input  logic [DEG_W-1:0]  divisor,
  output logic [RANK_W-1:0] quotient,
  output logic              done
);

  logic [DEG_W-1:0]  dvsr;
  logic [DEG_W-1:0]  rem;
  logic [RANK_W-1:0] quo;
  logic [CNT_W-1:0]  count;
  logic              busy;
  logic [DEG_W:0]    trial;
  logic [DEG_W:0]    trial_sub;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign trial     = {rem, quo[RANK_W-1]};
  assign trial_sub = trial - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        dvsr  <= divisor;
        rem   <= '0;
        quo   <= dividend;
      end else if (busy) begin
        if (!trial_sub[DEG_W]) begin
          rem <= trial_sub[DEG_W-1:0];
          quo <= {quo[RANK_W-2:0], 1'b1};
        end else begin
          rem <= trial[DEG_W-1:0];
          quo <= {quo[RANK_W-2:0], 1'b0};
        end
        count <= count + 1'b1;
        if (count == CNT_W'(RANK_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

### hw/rtl/prpn_dp.sv
// Datapath: configuration registers, divider, saturating sum, damping multiply,
// tolerance compare and the result register. Depends on prpn_pkg and prpn_div.
module prpn_dp import prpn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [RANK_W-1:0]     neighbor_rank,
  input  logic [DEG_W-1:0]      neighbor_outdeg,
  input  logic                  has_edge,
  input  logic                  last_edge,
  input  logic [RANK_W-1:0]     old_rank,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RANK_W-1:0]     new_rank,
  output logic                  changed
);

  logic [DAMP_W-1:0] damping;
  logic [RANK_W-1:0] tolerance;
  logic [SUM_W-1:0]  sum;
  logic              node_last;
  logic [RANK_W-1:0] node_old_rank;
  logic [PROD_W-1:0] p_lo;
  logic [PROD_W-1:0] p_hi;
  logic [RANK_W-1:0] value;

  logic [RANK_W-1:0] quotient;
  logic              div_done;
  logic [SUM_W:0]    sum_add;
  logic [DAMP_W-1:0] damp_eff;
  logic [DAMP_W-1:0] jump;
  logic [HALF_W-1:0] mul_opnd;
  logic [PROD_W-1:0] product;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-DAMP_FRAC-1:0] scaled;
  logic [RANK_W-1:0] diff;
  logic              upd;

  prpn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (neighbor_rank),
    .divisor  (neighbor_outdeg),
    .quotient (quotient),
    .done     (div_done)
  );

  // Damping above one acts as one.
  assign damp_eff = (damping > DAMP_ONE) ? DAMP_ONE : damping;
  assign jump     = DAMP_ONE - damp_eff;

  assign sum_add  = {1'b0, sum} + (SUM_W + 1)'(quotient);

  // One shared multiplier serves both halves of the sum.
  assign mul_opnd = cmd.mul_hi ? sum[SUM_W-1:HALF_W] : sum[HALF_W-1:0];
  assign product  = PROD_W'(damp_eff) * PROD_W'(mul_opnd);

  assign acc    = {p_hi, {HALF_W{1'b0}}} + ACC_W'(p_lo) + (ACC_W'(jump) << FRAC_BITS);
  assign scaled = acc[ACC_W-1:DAMP_FRAC];

  assign diff = (value >= node_old_rank) ? value - node_old_rank : node_old_rank - value;
  assign upd  = diff > tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      damping   <= DAMP_RESET;
      tolerance <= TOL_RESET;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DAMPING:   damping   <= cfg_data[DAMP_W-1:0];
          CFG_TOLERANCE: tolerance <= cfg_data[RANK_W-1:0];
          default: ;
        endcase
      end
      if (cmd.acc) begin
        sum <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        sum       <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      node_last     <= last_edge;
      node_old_rank <= old_rank;
    end
    if (cmd.mul_lo) begin
      p_lo <= product;
    end
    if (cmd.mul_hi) begin
      p_hi <= product;
    end
    if (cmd.fin) begin
      value <= (|scaled[ACC_W-DAMP_FRAC-1:RANK_W]) ? RANK_MAX : scaled[RANK_W-1:0];
    end
    if (cmd.emit) begin
      new_rank <= upd ? value : node_old_rank;
      changed  <= upd;
    end
  end

  always_comb begin
    status.in_work   = has_edge && (neighbor_outdeg != '0);
    status.in_last   = last_edge;
    status.node_last = node_last;
    status.div_done  = div_done;
    status.out_free  = !out_valid || out_ready;
  end

endmodule

### hw/rtl/prpn_ctrl.sv
// Controller state machine: sequences divide, accumulate, multiply and compare.
// Depends on prpn_pkg for the command and status structs.
module prpn_ctrl import prpn_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ACC,
    S_MUL_LO,
    S_MUL_HI,
    S_FIN,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.in_work) begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end else if (status.in_last) begin
            state_next = S_MUL_LO;
          end
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = status.node_last ? S_MUL_LO : S_IDLE;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hw/rtl/pagerank_pull_node_update_unit.sv
// PageRank pull node update: top level joining the controller and the datapath.
// An edge item with nonzero out-degree passes through accept, the divider steps (one per
// quotient bit), a step to see the divider finish, and accumulate; other non-final items
// are only accepted. The final item of a node adds two multiply halves, scale and saturate,
// and compare, plus any wait for the result register to empty.
// Synchronous active-high reset: sum cleared, damping 55706, tolerance 6554, no result held.
module pagerank_pull_node_update_unit import prpn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  prpn_in_if.sink               edges,
  prpn_out_if.source            ranks
);

  // The block works on one item at a time. The divider is the long pole: it produces one
  // quotient bit per cycle, so every contributing edge holds the input for its full length.
  // The result register decouples the output side, so a new node's edges are taken while
  // the previous node's result still waits to be consumed.

  cmd_t    cmd;
  status_t status;

  prpn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (edges.valid),
    .in_ready (edges.ready),
    .status   (status),
    .cmd      (cmd)
  );

  prpn_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .status          (status),
    .neighbor_rank   (edges.neighbor_rank),
    .neighbor_outdeg (edges.neighbor_outdeg),
    .has_edge        (edges.has_edge),
    .last_edge       (edges.last_edge),
    .old_rank        (edges.old_rank),
    .out_valid       (ranks.valid),
    .out_ready       (ranks.ready),
    .new_rank        (ranks.new_rank),
    .changed         (ranks.changed)
  );

  // After the final item of a node, the finishing steps must hold off the next item.
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    (edges.valid && edges.ready && edges.last_edge) |=> !edges.ready)
    else $error("input taken right after the final item of a node");

  // A contributing edge keeps the input closed while the divider runs.
  a_div_blocks: assert property (@(posedge clk) disable iff (rst)
    (edges.valid && edges.ready && edges.has_edge && (edges.neighbor_outdeg != '0))
      |=> !edges.ready)
    else $error("input taken while a division is in progress");

  // A new result appears only from the compare step, never while the input is open.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(ranks.valid) |-> $past(!edges.ready))
    else $error("result appeared without a completed node");

endmodule

### tb/testbench.sv
// Self-checking testbench for pagerank_pull_node_update_unit: in-edge items, register writes,
// a prediction of every node result and a field-by-field check of each one.
// Depends on prpn_pkg and on the prpn_in_if and prpn_out_if channel interfaces of the RTL.
module testbench;
  import prpn_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 12;
  // Long enough for an edge's division and the closing steps, so this covers any work in flight.
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES   = 800;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int REPORT_LIMIT  = 10;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int RANDOM_PHASES = 7;
  localparam logic [15:0] RX_MASK = 16'b1011_0011_1000_1110;

  // One node result as the block should deliver it.
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              changed;
  } node_result_t;

  // Ways in which the receiver takes results.
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_style_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  prpn_in_if  edges_ch();
  prpn_out_if ranks_ch();

  pagerank_pull_node_update_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .edges(edges_ch),
    .ranks(ranks_ch)
  );

  // Predicted state of the block: the running in-edge sum and the two registers.
  logic [SUM_W-1:0]  model_sum;
  logic [DAMP_W-1:0] model_damping;
  logic [RANK_W-1:0] model_tolerance;
  node_result_t      rank_queue[$];

  // The stimulus keeps its own idea of the registers so that it can aim old ranks
  // close to the value the block will compute.
  logic [DAMP_W-1:0] stim_damping = DAMP_RESET;
  logic [RANK_W-1:0] stim_tolerance = TOL_RESET;

  int unsigned cycle_count = 0;
  int          rank_errors = 0;
  int          items_sent = 0;
  int          results_checked = 0;
  int          ranks_replaced = 0;
  int          settings_used = 1;
  int          burst_left = 0;

  logic        hold_on = 1'b0;
  event        hold_go;
  rx_style_t   rx_style = RX_OPEN;
  int unsigned rx_tick = 0;

  always #(HALF_PERIOD) clk = ~clk;

  // The run is bounded; reaching the limit means the block hung or lost results.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Value the block computes at the end of a node: damping times the sum plus the jump
  // term, with damping clamped to one and the result clamped to the top of the rank range.
  function automatic logic [RANK_W-1:0] damped_rank(input logic [SUM_W-1:0] total,
                                                    input logic [DAMP_W-1:0] damp);
    logic [DAMP_W-1:0] d;
    logic [63:0]       acc;
    d = (damp > DAMP_ONE) ? DAMP_ONE : damp;
    acc = (64'(d) * 64'(total) + (64'(DAMP_ONE - d) << FRAC_BITS)) >> DAMP_FRAC;
    return (acc > 64'(RANK_MAX)) ? RANK_MAX : acc[RANK_W-1:0];
  endfunction

  function automatic void note_error(input string msg);
    rank_errors++;
    if (rank_errors <= REPORT_LIMIT) begin
      $display("mismatch %0d at cycle %0d: %s", rank_errors, cycle_count, msg);
    end
  endfunction

  // Predictor. It follows every register write and every accepted item at the same
  // rising edge as the block, and queues one expected result per closed node.
  always @(posedge clk) begin : predict_ranks
    logic [RANK_W-1:0] quotient;
    logic [RANK_W-1:0] fresh;
    logic [RANK_W-1:0] distance;
    logic [SUM_W:0]    widened;
    node_result_t      outcome;
    if (rst) begin
      model_sum = '0;
      model_damping = DAMP_RESET;
      model_tolerance = TOL_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DAMPING:   model_damping = cfg_data[DAMP_W-1:0];
          CFG_TOLERANCE: model_tolerance = cfg_data[RANK_W-1:0];
          default: ;
        endcase
      end
      if (edges_ch.valid && edges_ch.ready) begin
        // Edges with zero out-degree and items without an edge add nothing.
        if (edges_ch.has_edge && edges_ch.neighbor_outdeg != '0) begin
          quotient = edges_ch.neighbor_rank / edges_ch.neighbor_outdeg;
          widened = {1'b0, model_sum} + (SUM_W + 1)'(quotient);
          model_sum = widened[SUM_W] ? SUM_MAX : widened[SUM_W-1:0];
        end
        if (edges_ch.last_edge) begin
          fresh = damped_rank(model_sum, model_damping);
          distance = (fresh >= edges_ch.old_rank) ? fresh - edges_ch.old_rank
                                                  : edges_ch.old_rank - fresh;
          if (distance > model_tolerance) begin
            outcome.rank = fresh;
            outcome.changed = 1'b1;
          end else begin
            outcome.rank = edges_ch.old_rank;
            outcome.changed = 1'b0;
          end
          rank_queue = {rank_queue, outcome};
          model_sum = '0;
        end
      end
    end
  end

  // Checker. Each result taken from the block is matched against the oldest expectation.
  always @(posedge clk) begin : check_ranks
    node_result_t want;
    if (!rst && ranks_ch.valid && ranks_ch.ready) begin
      if (rank_queue.size() == 0) begin
        note_error($sformatf("result with none pending: new_rank %h changed %b",
                             ranks_ch.new_rank, ranks_ch.changed));
      end else begin
        want = rank_queue.pop_front();
        results_checked++;
        if (ranks_ch.new_rank !== want.rank || ranks_ch.changed !== want.changed) begin
          note_error($sformatf("new_rank %h (want %h), changed %b (want %b)",
                               ranks_ch.new_rank, want.rank, ranks_ch.changed, want.changed));
        end else if (want.changed) begin
          ranks_replaced++;
        end
      end
    end
  end

  // Receiver. The style is redrawn at random periodically: always ready, random stalls,
  // a fixed repeating pattern, or mostly stalled. A hold-off overrides all of them.
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 512 == 511) begin
      rx_style <= rx_style_t'($urandom_range(0, 3));
    end
    if (rst || hold_on) begin
      ranks_ch.ready <= 1'b0;
    end else begin
      case (rx_style)
        RX_OPEN:    ranks_ch.ready <= 1'b1;
        RX_RANDOM:  ranks_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: ranks_ch.ready <= RX_MASK[rx_tick[3:0]];
        default:    ranks_ch.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Long hold-off of the receiver, counted here so the sender keeps offering meanwhile.
  always begin
    @(hold_go);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_on <= 1'b0;
  end

  // Offers one item and returns at the falling edge after it was accepted. Items come in
  // bursts of random length; between bursts valid drops for a random number of cycles,
  // and about a third of the bursts follow on without any gap.
  task automatic send_item(input logic [RANK_W-1:0] rank, input logic [DEG_W-1:0] deg,
                           input logic has, input logic last, input logic [RANK_W-1:0] old);
    int pause;
    if (burst_left == 0) begin
      pause = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (pause != 0) begin
        edges_ch.valid <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    edges_ch.valid <= 1'b1;
    edges_ch.neighbor_rank <= rank;
    edges_ch.neighbor_outdeg <= deg;
    edges_ch.has_edge <= has;
    edges_ch.last_edge <= last;
    edges_ch.old_rank <= old;
    @(posedge clk);
    while (!edges_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Stops offering items and waits until the block has delivered everything and is idle,
  // so that registers may be written.
  task automatic settle();
    edges_ch.valid <= 1'b0;
    burst_left = 0;
    while (rank_queue.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes both registers on consecutive cycles; only called while the block is idle.
  task automatic set_regs(input logic [CFG_DATA_W-1:0] damp_word,
                          input logic [CFG_DATA_W-1:0] tol_word);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DAMPING;
    cfg_data <= damp_word;
    @(negedge clk);
    cfg_index <= CFG_TOLERANCE;
    cfg_data <= tol_word;
    @(negedge clk);
    cfg_we <= 1'b0;
    stim_damping = damp_word[DAMP_W-1:0];
    stim_tolerance = tol_word[RANK_W-1:0];
    settings_used++;
  endtask

  // One node of n_items items with random content. The closing item carries an old rank
  // that is random, equal to the new value, exactly one tolerance away, one step beyond
  // it, or somewhere within two tolerances, so that both outcomes occur often.
  task automatic random_node(input int n_items);
    logic [SUM_W-1:0]  guess;
    logic [RANK_W-1:0] rank;
    logic [RANK_W-1:0] old;
    logic [DEG_W-1:0]  deg;
    logic              has;
    longint            aim;
    longint            offset;
    int                k;
    guess = '0;
    for (k = 0; k < n_items; k++) begin
      case ($urandom_range(0, 7))
        0:       rank = RANK_MAX;
        1:       rank = $urandom_range(0, 255);
        2:       rank = '0;
        default: rank = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0:       deg = '0;
        1:       deg = {DEG_W{1'b1}};
        2, 3:    deg = DEG_W'($urandom);
        4:       deg = DEG_W'(1);
        default: deg = DEG_W'($urandom_range(1, 16));
      endcase
      has = ($urandom_range(0, 9) != 0);
      if (has && deg != '0) begin
        guess = guess + rank / deg;
      end
      old = $urandom;
      if (k == n_items - 1 && $urandom_range(0, 4) != 0) begin
        aim = longint'(damped_rank(guess, stim_damping));
        case ($urandom_range(0, 3))
          0:       offset = 0;
          1:       offset = longint'(stim_tolerance);
          2:       offset = longint'(stim_tolerance) + 1;
          default: offset = longint'($urandom) % (2 * longint'(stim_tolerance) + 1);
        endcase
        aim = ($urandom_range(0, 1) != 0) ? aim + offset : aim - offset;
        if (aim < 0) begin
          aim = 0;
        end else if (aim > longint'(RANK_MAX)) begin
          aim = longint'(RANK_MAX);
        end
        old = aim[RANK_W-1:0];
      end
      send_item(rank, deg, has, k == n_items - 1, old);
    end
  endtask

  // Field extremes and every special case, each under a register setting that shows it.
  task automatic test_directed();
    // Reset settings: damping about 0.85, tolerance about 0.1.
    send_item('0, '0, 1'b0, 1'b1, '0);                   // node without in-edges
    send_item(RANK_MAX, '0, 1'b1, 1'b1, RANK_MAX);       // only a zero out-degree edge
    send_item(RANK_MAX, DEG_W'(1), 1'b1, 1'b0, '0);
    send_item(RANK_MAX, DEG_W'(1), 1'b1, 1'b1, '0);      // new value clamps at the top
    send_item(RANK_MAX, {DEG_W{1'b1}}, 1'b1, 1'b0, RANK_MAX);
    send_item(32'hDEAD_BEEF, DEG_W'(3), 1'b0, 1'b0, 32'h1234_5678);  // no edge, not last
    send_item(32'h0002_0000, DEG_W'(2), 1'b1, 1'b1, 32'h0000_C000);
    settle();
    // Damping of exactly one: no jump term, the new value is the sum itself.
    set_regs(32'(DAMP_ONE), 32'd100);
    send_item(32'd1000, DEG_W'(1), 1'b1, 1'b1, 32'd1100);  // change equal to tolerance: kept
    send_item(32'd1000, DEG_W'(1), 1'b1, 1'b1, 32'd1101);  // one beyond it: replaced
    send_item(32'd1000, DEG_W'(1), 1'b1, 1'b1, 32'd899);   // one beyond it on the other side
    send_item(RANK_MAX, DEG_W'(1), 1'b1, 1'b1, RANK_MAX);  // exactly the top, no change
    settle();
    // Zero damping gives one for every node, and the largest tolerance keeps every rank.
    set_regs('0, {CFG_DATA_W{1'b1}});
    send_item(RANK_MAX, DEG_W'(1), 1'b1, 1'b1, '0);
    send_item('0, '0, 1'b0, 1'b1, RANK_MAX);
    settle();
    // Damping above one is taken as one; with zero tolerance any change replaces the rank.
    set_regs({CFG_DATA_W{1'b1}}, '0);
    send_item(RANK_MAX, DEG_W'(1), 1'b1, 1'b0, '0);
    send_item(32'd5, DEG_W'(1), 1'b1, 1'b1, RANK_MAX);    // sum beyond the rank range
    send_item('0, '0, 1'b0, 1'b1, '0);                    // no jump term at all
    settle();
    set_regs(32'(DAMP_ONE) + 32'd1, 32'(TOL_RESET));
    send_item(32'h0001_0000, DEG_W'(1), 1'b1, 1'b1, 32'h0001_0000);
    settle();
  endtask

  // Random nodes under a series of register settings, extremes among them.
  task automatic test_random_settings();
    int phase;
    int goal;
    int n;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        0:       set_regs(32'(DAMP_RESET), 32'(TOL_RESET));
        1:       set_regs('0, '0);
        2:       set_regs(32'(DAMP_ONE), '0);
        3:       set_regs({CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}});
        4:       set_regs($urandom_range(0, DAMP_ONE), $urandom_range(0, 1 << 20));
        5:       set_regs($urandom, $urandom);
        default: set_regs($urandom_range(40000, DAMP_ONE), $urandom_range(0, 65536));
      endcase
      goal = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_sent < goal) begin
        n = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 6);
        random_node(n);
      end
    end
    settle();
  endtask

  // The receiver holds off for a long stretch while short nodes keep coming, so a result waits in
  // the result register, the next node's result waits behind it and the block has to stall its input.
  task automatic test_result_backpressure();
    int k;
    settle();
    set_regs(32'(DAMP_RESET), 32'(TOL_RESET));
    -> hold_go;
    for (k = 0; k < 40; k++) begin
      if (k % 8 == 7) begin
        random_node(2);
      end else begin
        send_item($urandom, DEG_W'($urandom), 1'b0, 1'b1, $urandom);
      end
    end
    settle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_DAMPING;
    cfg_data = '0;
    edges_ch.valid = 1'b0;
    edges_ch.neighbor_rank = '0;
    edges_ch.neighbor_outdeg = '0;
    edges_ch.has_edge = 1'b0;
    edges_ch.last_edge = 1'b0;
    edges_ch.old_rank = '0;
    ranks_ch.ready = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_settings();
    test_result_backpressure();

    $display("covered %0d items, %0d node results (%0d ranks replaced), %0d register settings",
             items_sent, results_checked, ranks_replaced, settings_used);
    $display("receiver held off once for %0d cycles; %0d mismatches counted",
             HOLD_CYCLES, rank_errors);
    if (rank_errors == 0 && rank_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/prpn_pkg.sv
hw/rtl/prpn_in_if.sv
hw/rtl/prpn_out_if.sv
hw/rtl/prpn_div.sv
hw/rtl/prpn_dp.sv
hw/rtl/prpn_ctrl.sv
hw/rtl/pagerank_pull_node_update_unit.sv
tb/testbench.sv
